[hdl/bpa_pkg.sv]
package bpa_pkg;

    // Map geometry
    localparam int WORD_BITS = 32;
    localparam int MAP_WORDS = 1024;
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int TAKE_W    = BIT_W + 1;
    localparam int NW_W      = $clog2(MAP_WORDS + 1);
    localparam int CAP       = MAP_WORDS * WORD_BITS;

    // Field widths
    localparam int MODE_W  = 2;
    localparam int PAGE_W  = 15;
    localparam int COUNT_W = 16;
    localparam int NEED_W  = COUNT_W + 1;
    localparam int STAT_W  = 2;

    // Register port
    localparam int PADDR_W = 3;
    localparam int DATA_W  = 32;
    localparam logic REG_TOTAL = 1'b0;
    localparam logic [COUNT_W-1:0] TOTAL_RST = 16'd32768;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_ALLOC_PAGE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE_PAGE    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ALLOC_REGION = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FREE_REGION  = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOMEM  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_DOUBLE = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISP,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FILL,
        S_FREE_RD,
        S_FREE_MOD,
        S_FREE_CNT,
        S_DONE
    } t_state;

endpackage

[hdl/bitmap_page_allocator.sv]
// Next-fit bitmap page allocator.
// Request channel: drive i_mode/i_page/i_count and raise start; the word is
// taken at a clock edge where start is high and busy is low. busy stays high
// until the result has been shown. Modes: allocate page, free page,
// allocate region, free region.
// Result channel: o_done is high for exactly one cycle with o_status,
// o_page_out and o_used_pages valid; the receiver cannot stall it.
// Register port (APB-style, pready tied high): total_pages at byte address 0.
// States per request, from accept to the return to S_IDLE; the result is shown in
// S_DONE, the last of them. All work goes through the bitmap RAM (one write port, one read port):
//   allocate page   : S_DISP, then S_SCAN_RD and S_SCAN_CHK per word scanned
//   allocate region : S_DISP, S_SCAN_RD and S_SCAN_CHK per word scanned, then S_FILL per word filled
//   free page/region: S_DISP, then S_FREE_RD, S_FREE_MOD and S_FREE_CNT per word touched
//   failed range check or no searchable word: S_DISP, then straight to S_DONE
// One request is in flight at a time.
// Reset: a clearing pass writes every bitmap word (MAP_WORDS, 1024) as fully used
// with busy high; register writes are taken meanwhile.
module bitmap_page_allocator
    import bpa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready,
    input  logic                 start,
    output logic                 busy,
    input  logic [MODE_W-1:0]    i_mode,
    input  logic [PAGE_W-1:0]    i_page,
    input  logic [COUNT_W-1:0]   i_count,
    output logic                 o_done,
    output logic [STAT_W-1:0]    o_status,
    output logic [PAGE_W-1:0]    o_page_out,
    output logic [COUNT_W-1:0]   o_used_pages
);

    localparam logic [WORD_BITS-1:0] FULL = '1;

    function automatic logic [WORD_BITS-1:0] low_bits(input logic [TAKE_W-1:0] n);
        logic [WORD_BITS-1:0] ones;
        ones = '1;
        return (n == '0) ? '0 : (ones >> (TAKE_W'(WORD_BITS) - n));
    endfunction

    // Bitmap RAM
    logic [WORD_BITS-1:0] r_map [MAP_WORDS];
    logic [WORD_BITS-1:0] r_rdata;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata;

    // Control and datapath registers
    t_state              r_state,  n_state;
    logic [COUNT_W-1:0]  r_total;
    logic [COUNT_W-1:0]  r_used,   n_used;
    logic [ADDR_W-1:0]   r_cursor, n_cursor;
    logic [ADDR_W-1:0]   r_clr,    n_clr;
    logic [MODE_W-1:0]   r_mode,   n_mode;
    logic [COUNT_W-1:0]  r_p,      n_p;
    logic [COUNT_W-1:0]  r_rem,    n_rem;
    logic [COUNT_W-1:0]  r_cnt,    n_cnt;
    logic [NW_W-1:0]     r_need,   n_need;
    logic [ADDR_W-1:0]   r_w,      n_w;
    logic [NW_W-1:0]     r_k,      n_k;
    logic [NW_W-1:0]     r_run,    n_run;
    logic [ADDR_W-1:0]   r_fw,     n_fw;
    logic                r_dbl,    n_dbl;
    logic [TAKE_W-1:0]   r_pop,    n_pop;
    logic [STAT_W-1:0]   r_status, n_status;
    logic [PAGE_W-1:0]   r_page_out, n_page_out;

    // Shared datapath terms
    logic [COUNT_W-1:0]  eff;
    logic [NW_W-1:0]     nw;
    logic [ADDR_W-1:0]   start_w;
    logic [NEED_W-1:0]   need;
    logic [BIT_W-1:0]    lz;
    logic [NW_W-1:0]     run_new;
    logic [ADDR_W-1:0]   w_next;
    logic [ADDR_W-1:0]   region_first;
    logic [BIT_W-1:0]    part;
    logic [BIT_W-1:0]    lo;
    logic [TAKE_W-1:0]   avail;
    logic [TAKE_W-1:0]   n_take;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] set_bits;
    logic [TAKE_W-1:0]   pop;
    logic [ADDR_W-1:0]   p_word;
    logic [COUNT_W:0]    add_sum;
    logic [COUNT_W-1:0]  used_sat;

    assign pready       = 1'b1;
    assign prdata       = (paddr[2] == REG_TOTAL) ? DATA_W'(r_total) : '0;
    assign busy         = (r_state != S_IDLE);
    assign o_done       = (r_state == S_DONE);
    assign o_status     = r_status;
    assign o_page_out   = r_page_out;
    assign o_used_pages = r_used;

    // Derive search bounds and per-word terms
    always_comb begin
        eff     = (32'(r_total) < CAP) ? r_total : COUNT_W'(CAP);
        nw      = NW_W'(eff / WORD_BITS);
        start_w = (NW_W'(r_cursor) < nw) ? r_cursor : '0;
        need    = NEED_W'((NEED_W'(r_cnt) + NEED_W'(WORD_BITS - 1)) / WORD_BITS);
        part    = BIT_W'(r_cnt % WORD_BITS);

        lz = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!r_rdata[i]) lz = BIT_W'(i);
        end

        run_new = (r_rdata == '0) ? (((r_w == '0) ? NW_W'(0) : r_run) + NW_W'(1)) : '0;
        w_next  = ((NW_W'(r_w) + NW_W'(1)) == nw) ? '0 : r_w + ADDR_W'(1);
        region_first = ADDR_W'(NW_W'(r_w) + NW_W'(1) - r_need);

        lo     = BIT_W'(r_p % WORD_BITS);
        avail  = TAKE_W'(WORD_BITS) - TAKE_W'(lo);
        n_take = (r_rem < COUNT_W'(avail)) ? TAKE_W'(r_rem) : avail;
        mask   = low_bits(n_take) << lo;
        set_bits = r_rdata & mask;
        pop = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            pop = pop + TAKE_W'(set_bits[i]);
        end
        p_word = ADDR_W'(r_p / WORD_BITS);

        add_sum  = (COUNT_W + 1)'(r_used)
                 + (COUNT_W + 1)'((r_mode == MODE_ALLOC_PAGE) ? COUNT_W'(1) : r_cnt);
        used_sat = add_sum[COUNT_W] ? '1 : add_sum[COUNT_W-1:0];
    end

    // Sequencer: next state, RAM access and register updates
    always_comb begin
        n_state    = r_state;
        n_used     = r_used;
        n_cursor   = r_cursor;
        n_clr      = r_clr;
        n_mode     = r_mode;
        n_p        = r_p;
        n_rem      = r_rem;
        n_cnt      = r_cnt;
        n_need     = r_need;
        n_w        = r_w;
        n_k        = r_k;
        n_run      = r_run;
        n_fw       = r_fw;
        n_dbl      = r_dbl;
        n_pop      = r_pop;
        n_status   = r_status;
        n_page_out = r_page_out;
        mem_we     = 1'b0;
        mem_waddr  = r_w;
        mem_raddr  = r_w;
        mem_wdata  = FULL;

        case (r_state)
            S_CLEAR: begin
                // Mark every word used
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = FULL;
                n_clr     = r_clr + ADDR_W'(1);
                if (r_clr == ADDR_W'(MAP_WORDS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    n_mode  = i_mode;
                    n_p     = COUNT_W'(i_page);
                    n_rem   = (i_mode == MODE_FREE_PAGE) ? COUNT_W'(1) : i_count;
                    n_cnt   = i_count;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_status   = STAT_OK;
                n_page_out = '0;
                n_k        = '0;
                n_w        = start_w;
                n_run      = '0;
                n_pop      = '0;
                n_dbl      = 1'b0;
                case (r_mode)
                    MODE_ALLOC_PAGE: begin
                        if (nw == '0) begin
                            n_status = STAT_NOMEM;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_SCAN_RD;
                        end
                    end
                    MODE_ALLOC_REGION: begin
                        if (r_cnt == '0 || nw == '0 || need > NEED_W'(nw)) begin
                            n_status = STAT_NOMEM;
                            n_state  = S_DONE;
                        end else begin
                            n_need  = NW_W'(need);
                            n_state = S_SCAN_RD;
                        end
                    end
                    default: begin
                        // Free modes: range check, then walk the words
                        if (r_p >= eff || r_rem > (eff - r_p)) begin
                            n_status = STAT_RANGE;
                            n_state  = S_DONE;
                        end else if (r_rem == '0) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_FREE_RD;
                        end
                    end
                endcase
            end
            S_SCAN_RD: begin
                mem_raddr = r_w;
                n_state   = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (r_mode == MODE_ALLOC_PAGE && r_rdata != FULL) begin
                    // Take the lowest free bit of this word
                    mem_we     = 1'b1;
                    mem_waddr  = r_w;
                    mem_wdata  = r_rdata | (WORD_BITS'(1) << lz);
                    n_cursor   = r_w;
                    n_used     = used_sat;
                    n_page_out = PAGE_W'(32'(r_w) * WORD_BITS + 32'(lz));
                    n_state    = S_DONE;
                end else if (r_mode != MODE_ALLOC_PAGE && run_new == r_need) begin
                    // Run found: fill it from its first word
                    n_fw       = region_first;
                    n_cursor   = w_next;
                    n_used     = used_sat;
                    n_page_out = PAGE_W'(32'(region_first) * WORD_BITS);
                    n_state    = S_FILL;
                end else if ((r_k + NW_W'(1)) == nw) begin
                    n_status = STAT_NOMEM;
                    n_state  = S_DONE;
                end else begin
                    n_run   = run_new;
                    n_k     = r_k + NW_W'(1);
                    n_w     = w_next;
                    n_state = S_SCAN_RD;
                end
            end
            S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = r_fw;
                mem_wdata = (r_fw == r_w && part != '0) ? low_bits(TAKE_W'(part)) : FULL;
                if (r_fw == r_w) n_state = S_DONE;
                else             n_fw    = r_fw + ADDR_W'(1);
            end
            S_FREE_RD: begin
                mem_raddr = p_word;
                n_state   = S_FREE_MOD;
            end
            S_FREE_MOD: begin
                // Clear the pages of this word, note bits already free
                mem_we    = 1'b1;
                mem_waddr = p_word;
                mem_wdata = r_rdata & ~mask;
                if (set_bits != mask) n_dbl = 1'b1;
                n_pop   = pop;
                n_p     = r_p + COUNT_W'(n_take);
                n_rem   = r_rem - COUNT_W'(n_take);
                n_state = S_FREE_CNT;
            end
            S_FREE_CNT: begin
                n_used = (r_used > COUNT_W'(r_pop)) ? r_used - COUNT_W'(r_pop) : '0;
                if (r_rem == '0) begin
                    n_status = r_dbl ? STAT_DOUBLE : STAT_OK;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_FREE_RD;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Bitmap RAM port
    always_ff @(posedge i_clk) begin
        if (mem_we) r_map[mem_waddr] <= mem_wdata;
        r_rdata <= r_map[mem_raddr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_total  <= TOTAL_RST;
            r_used   <= TOTAL_RST;
            r_cursor <= '0;
            r_clr    <= '0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_cursor <= n_cursor;
            r_clr    <= n_clr;
            if (psel && penable && pwrite && paddr[2] == REG_TOTAL) begin
                r_total <= pwdata[COUNT_W-1:0];
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_p        <= n_p;
        r_rem      <= n_rem;
        r_cnt      <= n_cnt;
        r_need     <= n_need;
        r_w        <= n_w;
        r_k        <= n_k;
        r_run      <= n_run;
        r_fw       <= n_fw;
        r_dbl      <= n_dbl;
        r_pop      <= n_pop;
        r_status   <= n_status;
        r_page_out <= n_page_out;
    end

endmodule

[hdl/bpa_checker.sv]
module bpa_checker
    import bpa_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_done,
    input logic [STAT_W-1:0]  o_status,
    input logic [PAGE_W-1:0]  o_page_out,
    input logic [COUNT_W-1:0] o_used_pages
);

    // Accepted word keeps the block busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low after accepting a request");

    // Result strobe lasts one cycle and only while busy
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy ##1 !o_done)
        else $error("result strobe not a single busy cycle");

    // Failed requests report page zero
    a_fail_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != STAT_OK) |-> (o_page_out == '0))
        else $error("nonzero page on failed request");

    // Used count moves only while a request is in flight
    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && $past(!busy)) |-> $stable(o_used_pages))
        else $error("used count changed while idle");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (.*);
